FILE: hw/rtl/csc_pkg.sv
// csc_pkg: shared types, op codes, constants and calendar helper functions
// for the calendar/seconds converter. No dependencies.

package csc_pkg;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // Datapath op codes, issued by the controller once per cycle
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_D_YEAR   = 4'd2;
    localparam logic [3:0] OP_D_MONTH  = 4'd3;
    localparam logic [3:0] OP_D_DAY    = 4'd4;
    localparam logic [3:0] OP_D_HOUR   = 4'd5;
    localparam logic [3:0] OP_D_MIN    = 4'd6;
    localparam logic [3:0] OP_D_SEC    = 4'd7;
    localparam logic [3:0] OP_DIV_DAY  = 4'd8;
    localparam logic [3:0] OP_DIV_HOUR = 4'd9;
    localparam logic [3:0] OP_DIV_MIN  = 4'd10;
    localparam logic [3:0] OP_S_YEAR   = 4'd11;
    localparam logic [3:0] OP_S_MONTH  = 4'd12;
    localparam logic [3:0] OP_EMIT     = 4'd13;

    localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
    localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN     = 32'd60;

    localparam logic [15:0] DAYS_COMMON = 16'd365;
    localparam logic [15:0] DAYS_LEAP   = 16'd366;
    localparam logic [3:0]  MONTHS      = 4'd12;

    // Each division computes the quotient, then the remainder
    localparam logic [3:0] DIV_DAY_TOP  = 4'd1;
    localparam logic [3:0] DIV_HOUR_TOP = 4'd1;
    localparam logic [3:0] DIV_MIN_TOP  = 4'd1;

    // Reciprocals: 86400 = 128*675, 3600 = 16*225, 60 = 4*15
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15)

    typedef struct packed {
        logic [3:0] op;
    } csc_cmd_t;

    typedef struct packed {
        logic kind;          // captured direction of the item in work
        logic year_done;     // date->seconds: all whole years added
        logic month_done;    // date->seconds: all whole months added
        logic div_last;      // current division is on its last cycle
        logic s_year_stop;   // seconds->date: year walk finished
        logic s_month_stop;  // seconds->date: month walk finished
        logic out_free;      // output register can take a result
    } csc_stat_t;

    // Year offset y from 2000; only 2000, 2100 and 2200 are centuries in range
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'd0) && (y != 8'd100) && (y != 8'd200);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/csc_ctrl.sv
// csc_ctrl: sequencing state machine of the calendar/seconds converter.
// Issues one datapath op per cycle from datapath status. Uses csc_pkg.

module csc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  csc_pkg::csc_stat_t  stat,
    output csc_pkg::csc_cmd_t   cmd
);
    import csc_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_D_YEAR   = 4'd2;
    localparam logic [3:0] ST_D_MONTH  = 4'd3;
    localparam logic [3:0] ST_D_DAY    = 4'd4;
    localparam logic [3:0] ST_D_HOUR   = 4'd5;
    localparam logic [3:0] ST_D_MIN    = 4'd6;
    localparam logic [3:0] ST_D_SEC    = 4'd7;
    localparam logic [3:0] ST_DIV_DAY  = 4'd8;
    localparam logic [3:0] ST_DIV_HOUR = 4'd9;
    localparam logic [3:0] ST_DIV_MIN  = 4'd10;
    localparam logic [3:0] ST_S_YEAR   = 4'd11;
    localparam logic [3:0] ST_S_MONTH  = 4'd12;
    localparam logic [3:0] ST_EMIT     = 4'd13;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = stat.kind ? ST_DIV_DAY : ST_D_YEAR;
            end
            ST_D_YEAR: begin
                cmd.op = OP_D_YEAR;
                if (stat.year_done) state_next = ST_D_MONTH;
            end
            ST_D_MONTH: begin
                cmd.op = OP_D_MONTH;
                if (stat.month_done) state_next = ST_D_DAY;
            end
            ST_D_DAY: begin
                cmd.op     = OP_D_DAY;
                state_next = ST_D_HOUR;
            end
            ST_D_HOUR: begin
                cmd.op     = OP_D_HOUR;
                state_next = ST_D_MIN;
            end
            ST_D_MIN: begin
                cmd.op     = OP_D_MIN;
                state_next = ST_D_SEC;
            end
            ST_D_SEC: begin
                cmd.op     = OP_D_SEC;
                state_next = ST_EMIT;
            end
            ST_DIV_DAY: begin
                cmd.op = OP_DIV_DAY;
                if (stat.div_last) state_next = ST_DIV_HOUR;
            end
            ST_DIV_HOUR: begin
                cmd.op = OP_DIV_HOUR;
                if (stat.div_last) state_next = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
                cmd.op = OP_DIV_MIN;
                if (stat.div_last) state_next = ST_S_YEAR;
            end
            ST_S_YEAR: begin
                cmd.op = OP_S_YEAR;
                if (stat.s_year_stop) state_next = ST_S_MONTH;
            end
            ST_S_MONTH: begin
                cmd.op = OP_S_MONTH;
                if (stat.s_month_stop) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted item did not start processing");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> stat.out_free)
        else $error("result written while output register busy");

    a_emit_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && stat.out_free) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after emit");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cmd.op == OP_NONE || cmd.op == OP_LOAD))
        else $error("input ready while a conversion runs");

endmodule

FILE: hw/rtl/csc_dp.sv
// csc_dp: datapath of the calendar/seconds converter: accumulator, reciprocal
// divider, year/month walkers and the output register. Uses csc_pkg.

module csc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  csc_pkg::csc_cmd_t                 cmd,
    output csc_pkg::csc_stat_t                stat,
    input  logic [csc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [csc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import csc_pkg::*;

    logic        kind_reg;
    logic [7:0]  year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;      // input hour, later the hour result
    logic [5:0]  minute_reg;    // input minute, later the minute result
    logic [5:0]  second_reg;    // input second, later the second result
    logic [31:0] acc_reg;       // seconds total, or division remainder
    logic [15:0] q_reg;
    logic [3:0]  step_reg;
    logic [7:0]  cnt_reg;
    logic [15:0] days_reg;
    logic [7:0]  yr_reg;
    logic [3:0]  mon_reg;
    logic        m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic        out_free;
    logic        leap_in;
    logic [31:0] year_secs;
    logic [3:0]  month_clamp;
    logic [3:0]  month_before;
    logic [31:0] month_secs;
    logic [31:0] day_secs;
    logic [31:0] hour_secs;
    logic [31:0] minute_secs;
    logic [31:0] div_base;
    logic [50:0] day_prod;
    logic [26:0] hour_prod;
    logic [20:0] min_prod;
    logic [15:0] div_q;
    logic [31:0] div_prod;
    logic [31:0] acc_div;
    logic        yr_leap;
    logic [4:0]  s_mlen;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [M_TDATA_W-1:0] result;

    assign out_free = !m_tvalid_reg || m_tready;

    // date -> seconds terms
    assign leap_in   = is_leap(year_reg);
    assign year_secs = is_leap(cnt_reg) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
    always_comb begin
        if (month_reg == 4'd0) begin
            month_clamp = 4'd1;
        end else if (month_reg > MONTHS) begin
            month_clamp = MONTHS;
        end else begin
            month_clamp = month_reg;
        end
    end
    assign month_before = month_clamp - 4'd1;
    assign month_secs   = 32'(month_len(cnt_reg[3:0], leap_in)) * SECS_PER_DAY;
    assign day_secs     = 32'(day_reg) * SECS_PER_DAY;
    assign hour_secs    = 32'(hour_reg) * SECS_PER_HOUR;
    assign minute_secs  = 32'(minute_reg) * SECS_PER_MIN;

    // quotient by reciprocal multiply after dropping the power-of-two factor
    assign day_prod  = 51'(acc_reg[31:7]) * 51'(DAY_RECIP);
    assign hour_prod = 27'(acc_reg[16:4]) * 27'(HOUR_RECIP);
    assign min_prod  = 21'(acc_reg[11:2]) * 21'(MIN_RECIP);

    always_comb begin
        case (cmd.op)
            OP_DIV_DAY: begin
                div_base = SECS_PER_DAY;
                div_q    = day_prod[50:35];
            end
            OP_DIV_HOUR: begin
                div_base = SECS_PER_HOUR;
                div_q    = {11'd0, hour_prod[25:21]};
            end
            default: begin
                div_base = SECS_PER_MIN;
                div_q    = {10'd0, min_prod[19:14]};
            end
        endcase
    end
    assign div_prod = 32'(q_reg) * div_base;
    assign acc_div  = acc_reg - div_prod;

    // seconds -> date walkers
    assign yr_leap = is_leap(yr_reg);
    assign s_mlen  = month_len(mon_reg, yr_leap);

    assign stat.kind         = kind_reg;
    assign stat.year_done    = (cnt_reg == year_reg);
    assign stat.month_done   = (cnt_reg == {4'd0, month_before});
    assign stat.div_last     = (step_reg == 4'd0);
    assign stat.s_year_stop  = (days_reg < DAYS_COMMON) || (yr_leap && days_reg < DAYS_LEAP);
    assign stat.s_month_stop = (mon_reg >= MONTHS) || (days_reg < 16'(s_mlen));
    assign stat.out_free     = out_free;

    assign month_out = mon_reg + 4'd1;
    assign day_out   = days_reg[4:0] + 5'd1;
    assign result    = kind_reg
                     ? {6'd0, second_reg, minute_reg, hour_reg, day_out, month_out,
                        yr_reg, 32'd0}
                     : {40'd0, acc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                kind_reg   <= s_tuser;
                year_reg   <= s_tdata[7:0];
                month_reg  <= s_tdata[11:8];
                day_reg    <= s_tdata[16:12];
                hour_reg   <= s_tdata[21:17];
                minute_reg <= s_tdata[27:22];
                second_reg <= s_tdata[33:28];
                acc_reg    <= s_tuser ? s_tdata[65:34] : 32'd0;
                cnt_reg    <= 8'd0;
                q_reg      <= 16'd0;
                step_reg   <= DIV_DAY_TOP;
                yr_reg     <= 8'd0;
                mon_reg    <= 4'd0;
            end
            OP_D_YEAR: begin
                if (cnt_reg != year_reg) begin
                    acc_reg <= acc_reg + year_secs;
                    cnt_reg <= cnt_reg + 8'd1;
                end else begin
                    cnt_reg <= 8'd0;
                end
            end
            OP_D_MONTH: begin
                if (cnt_reg != {4'd0, month_before}) begin
                    acc_reg <= acc_reg + month_secs;
                    cnt_reg <= cnt_reg + 8'd1;
                end
            end
            // day zero wraps to one day back, as in 32-bit arithmetic
            OP_D_DAY:  acc_reg <= acc_reg + day_secs - SECS_PER_DAY;
            OP_D_HOUR: acc_reg <= acc_reg + hour_secs;
            OP_D_MIN:  acc_reg <= acc_reg + minute_secs;
            OP_D_SEC:  acc_reg <= acc_reg + 32'(second_reg);
            OP_DIV_DAY: begin
                if (step_reg != 4'd0) begin
                    q_reg    <= div_q;
                    step_reg <= step_reg - 4'd1;
                end else begin
                    acc_reg  <= acc_div;
                    days_reg <= q_reg;
                    step_reg <= DIV_HOUR_TOP;
                end
            end
            OP_DIV_HOUR: begin
                if (step_reg != 4'd0) begin
                    q_reg    <= div_q;
                    step_reg <= step_reg - 4'd1;
                end else begin
                    acc_reg  <= acc_div;
                    hour_reg <= q_reg[4:0];
                    step_reg <= DIV_MIN_TOP;
                end
            end
            OP_DIV_MIN: begin
                if (step_reg != 4'd0) begin
                    q_reg    <= div_q;
                    step_reg <= step_reg - 4'd1;
                end else begin
                    acc_reg    <= acc_div;
                    minute_reg <= q_reg[5:0];
                    second_reg <= acc_div[5:0];
                end
            end
            OP_S_YEAR: begin
                if (!stat.s_year_stop) begin
                    days_reg <= days_reg - (yr_leap ? DAYS_LEAP : DAYS_COMMON);
                    yr_reg   <= yr_reg + 8'd1;
                end
            end
            OP_S_MONTH: begin
                if (!stat.s_month_stop) begin
                    days_reg <= days_reg - 16'(s_mlen);
                    mon_reg  <= mon_reg + 4'd1;
                end
            end
            OP_EMIT: m_tdata_reg <= result;
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |=> m_tvalid_reg)
        else $error("emitted result not marked valid");

    a_year_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_D_YEAR && !stat.year_done) |=> (cnt_reg == $past(cnt_reg) + 8'd1))
        else $error("year counter did not advance");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_S_MONTH) |-> (mon_reg <= MONTHS))
        else $error("month walk ran past December");

    a_days_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_S_MONTH) |-> (days_reg < DAYS_LEAP))
        else $error("year walk left a full year of days");

endmodule

FILE: hw/rtl/calendar_seconds_converter.sv
// calendar_seconds_converter: date/time <-> seconds since 2000-01-01 00:00:00.
// Date to seconds: year walk, month walk to clamp(month), then the time terms.
// Seconds to date: day, hour, minute divisions, then year walk and month walk.
// One item at a time; the next item is taken once the result sits in the output
// register.
// aresetn (synchronous, active low) clears the controller and the output valid.

module calendar_seconds_converter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // year[7:0] month[11:8] day[16:12] hour[21:17] minute[27:22]
    // second[33:28] seconds_count[65:34], zero pad above
    input  logic [csc_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // res_seconds[31:0] res_year[39:32] res_month[43:40] res_day[48:44]
    // res_hour[53:49] res_minute[59:54] res_second[65:60], zero pad above
    output logic [csc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import csc_pkg::*;

    csc_cmd_t  cmd;
    csc_stat_t stat;

    csc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
